// ----- sv/line_ellipsoid_intersection_core_assert.svh -----
// Assertion macros, clocked on clk and disabled during arst_n.
`ifndef LINE_ELLIPSOID_INTERSECTION_CORE_ASSERT_SVH
`define LINE_ELLIPSOID_INTERSECTION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LEI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LEI_NEVER(lbl, cond, msg) `LEI_ASSERT(lbl, !(cond), msg)
`else
`define LEI_ASSERT(lbl, prop, msg)
`define LEI_NEVER(lbl, cond, msg)
`endif
`endif

// ----- sv/lei_pkg.sv -----
`default_nettype none
package lei_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int BIG_WIDTH_DEF   = 12 * COORD_WIDTH_DEF + 8;
	localparam int CFG_IDX_W       = 3;
	localparam int QUEUE_DEPTH     = 4;
	localparam int TU_HIT          = 0;
	localparam int TU_CLIPPED      = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_A   = 3'd0,
		REG_AXIS_B   = 3'd1,
		REG_AXIS_C   = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_CENTER_Z = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SETUP,
		BK_AXIS,
		BK_DISC,
		BK_CHECK,
		BK_ROOT,
		BK_PREP,
		BK_PMUL,
		BK_PDIV,
		BK_PSAT,
		BK_OUT
	} bk_state_t;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;
endpackage
`default_nettype wire

// ----- sv/line_ellipsoid_intersection_core.sv -----
// Channel  Dir  Signals                     Contents
// s_*      in   s_tvalid/tready, tdata 192  line_x, line_y, line_z, dir_x, dir_y, dir_z
// m_*      out  m_tvalid/tready, tdata 192  near_x, near_y, near_z, far_x, far_y, far_z
//                             tuser 2       hit, clipped
// cfg_*    in   cfg_we, cfg_index 3, data   axis_a, axis_b, axis_c, center_x/y/z
//
// A hit uses a bit-serial multiplier shared by 34 products, a radix-2 divider run six times
// (BW bits wide, BW = 12*COORD_WIDTH+8) and one square root. A zero direction skips the
// arithmetic and goes straight to the output. Input transfers go into a four-entry queue
// and continue while the back end works or a result waits in the output register, as long
// as the queue is not full.
// Reset sets the semi-axes to 1.0 and the center to the origin.
`default_nettype none
module line_ellipsoid_intersection_core import lei_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,  // line_x/y/z, dir_x/y/z
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_tdata,  // near_x/y/z, far_x/y/z
	output logic [1:0]                         m_tuser,  // hit, clipped
	input  logic                               cfg_we,
	input  logic [CFG_IDX_W-1:0]               cfg_index,
	input  logic [COORD_WIDTH-1:0]             cfg_data
);
	localparam int CW      = COORD_WIDTH;
	localparam int ENTRY_W = 9 * COORD_WIDTH + 4;
	localparam logic [CW-2:0] AXIS_ONE = (CW-1)'(64'd1 << FRAC_BITS);

	logic [CW-2:0]      axis_a_q, axis_b_q, axis_c_q;
	logic [CW-1:0]      center_x_q, center_y_q, center_z_q;
	logic               q_push, q_pop, q_full, q_empty;
	logic [ENTRY_W-1:0] q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_a_q   <= AXIS_ONE;
			axis_b_q   <= AXIS_ONE;
			axis_c_q   <= AXIS_ONE;
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AXIS_A:   axis_a_q   <= cfg_data[CW-2:0];
				REG_AXIS_B:   axis_b_q   <= cfg_data[CW-2:0];
				REG_AXIS_C:   axis_c_q   <= cfg_data[CW-2:0];
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_CENTER_Z: center_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lei_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.center_z (center_z_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	lei_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	lei_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.axis_a   (axis_a_q),
		.axis_b   (axis_b_q),
		.axis_c   (axis_c_q),
		.q_empty  (q_empty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);
endmodule
`default_nettype wire

// ----- sv/lei_queue.sv -----
`default_nettype none
module lei_queue import lei_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end
endmodule
`default_nettype wire

// ----- sv/lei_front.sv -----
`default_nettype none
module lei_front import lei_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic [COORD_WIDTH-1:0]        center_x,
	input  logic [COORD_WIDTH-1:0]        center_y,
	input  logic [COORD_WIDTH-1:0]        center_z,
	input  logic                          q_full,
	output logic                          q_push,
	output logic [9*COORD_WIDTH+3:0]      q_wdata
);
	localparam int CW = COORD_WIDTH;

	logic [CW-1:0] ctr [3];
	logic [CW-1:0] pnt [3];

	assign ctr[0] = center_x;
	assign ctr[1] = center_y;
	assign ctr[2] = center_z;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// entry: p, d, x = p - center (one bit wider), zero-direction flag
	always_comb begin
		q_wdata = '0;
		for (int i = 0; i < 3; i++) begin
			pnt[i] = s_tdata[i*CW +: CW];
			q_wdata[i*CW +: CW]     = pnt[i];
			q_wdata[(3+i)*CW +: CW] = s_tdata[(3+i)*CW +: CW];
			q_wdata[6*CW + i*(CW+1) +: CW+1] =
				{pnt[i][CW-1], pnt[i]} - {ctr[i][CW-1], ctr[i]};
		end
		q_wdata[9*CW+3] = (s_tdata[6*CW-1:3*CW] == '0);
	end
endmodule
`default_nettype wire

// ----- sv/lei_mul.sv -----
`default_nettype none
module lei_mul import lei_pkg::*; #(
	parameter int BIG_WIDTH = BIG_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [BIG_WIDTH-1:0] a,
	input  logic signed [BIG_WIDTH-1:0] b,
	output unit_sts_t                   sts,
	output logic signed [BIG_WIDTH-1:0] prod
);
	localparam int BW = BIG_WIDTH;

	logic                 busy_q, done_q, neg_q;
	logic [BW-1:0]        a_q, b_q;
	logic signed [BW-1:0] acc_q;

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod     = acc_q;

	// shift-add over the magnitude of b, stops when b runs out of ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b[BW-1] ? -b : b;
			neg_q <= b[BW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q != '0) begin
				if (b_q[0])
					acc_q <= acc_q + $signed(a_q);
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end else if (neg_q)
				acc_q <= -acc_q;
		end
	end
endmodule
`default_nettype wire

// ----- sv/lei_divsqrt.sv -----
`default_nettype none
module lei_divsqrt import lei_pkg::*; #(
	parameter int BIG_WIDTH = BIG_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  unit_ctl_t                   ctl,
	input  logic signed [BIG_WIDTH-1:0] num,
	input  logic signed [BIG_WIDTH-1:0] den,
	output unit_sts_t                   sts,
	output logic signed [BIG_WIDTH-1:0] res
);
	localparam int BW    = BIG_WIDTH;
	localparam int HW    = BW / 2;
	localparam int CNT_W = $clog2(BW + 1);

	logic                 busy_q, done_q, mode_q, neg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [BW:0]          rem_q;
	logic [BW-1:0]        nq_q, den_q;
	logic [HW-1:0]        root_q;
	logic signed [BW-1:0] res_q;
	logic [BW:0]          rem_div, rem_sqr, trial;
	logic                 div_ge, sqr_ge;
	logic [BW-1:0]        q_fix;

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = res_q;

	always_comb begin
		rem_div = {rem_q[BW-1:0], nq_q[BW-1]};
		rem_sqr = {rem_q[BW-2:0], nq_q[BW-1:BW-2]};
		trial   = (BW+1)'({root_q, 2'b01});
		div_ge  = (rem_div >= {1'b0, den_q});
		sqr_ge  = (rem_sqr >= trial);
		// floor for a negative dividend: -(q + 1) when the remainder is nonzero
		q_fix   = neg_q ? ((rem_q != '0) ? ~nq_q : -nq_q) : nq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.sqrt_mode ? CNT_W'(HW) : CNT_W'(BW);
			end else if (busy_q) begin
				if (cnt_q != '0)
					cnt_q <= cnt_q - 1'b1;
				else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.sqrt_mode;
			rem_q  <= '0;
			root_q <= '0;
			den_q  <= den;
			if (ctl.sqrt_mode) begin
				nq_q  <= num;
				neg_q <= 1'b0;
			end else begin
				nq_q  <= num[BW-1] ? -num : num;
				neg_q <= num[BW-1];
			end
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				if (mode_q) begin
					rem_q  <= sqr_ge ? rem_sqr - trial : rem_sqr;
					root_q <= {root_q[HW-2:0], sqr_ge};
					nq_q   <= nq_q << 2;
				end else begin
					rem_q <= div_ge ? rem_div - {1'b0, den_q} : rem_div;
					nq_q  <= {nq_q[BW-2:0], div_ge};
				end
			end else
				res_q <= mode_q ? $signed(BW'(root_q)) : $signed(q_fix);
		end
	end
endmodule
`default_nettype wire

// ----- sv/lei_back.sv -----
`default_nettype none
`include "line_ellipsoid_intersection_core_assert.svh"
module lei_back import lei_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [COORD_WIDTH-2:0]             axis_a,
	input  logic [COORD_WIDTH-2:0]             axis_b,
	input  logic [COORD_WIDTH-2:0]             axis_c,
	input  logic                               q_empty,
	input  logic [9*COORD_WIDTH+3:0]           q_rdata,
	output logic                               q_pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic [1:0]                         m_tuser
);
	localparam int CW    = COORD_WIDTH;
	localparam int BW    = 12 * COORD_WIDTH + 8;
	localparam int OUT_W = ((6 * COORD_WIDTH + 7) / 8) * 8;

	bk_state_t state_q, state_d;
	logic [2:0] idx_q, idx_d, sub_q, sub_d;
	logic [1:0] axis_q, axis_d;
	logic       side_q, side_d, pend_q, pend_d;
	logic       m_tvalid_q, out_load, out_free;

	logic signed [CW-1:0]   p_q [3];
	logic signed [CW-1:0]   d_q [3];
	logic signed [CW:0]     x_q [3];
	logic                   dzero;
	logic signed [BW-1:0]   wq_q [3];
	logic signed [BW-1:0]   u_q, k_q, l_q, m_q, t_q, disc_q, r_q, nn_q, np_q, den_q, s_q;
	logic [CW-1:0]          res_near_q [3];
	logic [CW-1:0]          res_far_q [3];
	logic                   res_hit_q, res_clip_q;
	logic [OUT_W-1:0]       m_tdata_q;
	logic [OUT_W-1:0]       out_word;
	logic [1:0]             m_tuser_q;

	logic                   in_mul;
	logic                   mul_start;
	logic signed [BW-1:0]   mul_a, mul_b, mul_prod;
	unit_sts_t              mul_sts, ds_sts;
	unit_ctl_t              ds_ctl;
	logic signed [BW-1:0]   ds_num, ds_res;
	logic                   fits;
	logic [CW-1:0]          sat_val;

	assign dzero = q_rdata[9*CW+3];

	lei_mul #(.BIG_WIDTH(BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sts    (mul_sts),
		.prod   (mul_prod)
	);

	lei_divsqrt #(.BIG_WIDTH(BW)) u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ds_ctl),
		.num    (ds_num),
		.den    (den_q),
		.sts    (ds_sts),
		.res    (ds_res)
	);

	assign in_mul = (state_q == BK_SETUP || state_q == BK_AXIS ||
		state_q == BK_DISC || state_q == BK_PMUL);
	assign mul_start        = pend_q && in_mul;
	assign ds_ctl.start     = pend_q && (state_q == BK_ROOT || state_q == BK_PDIV);
	assign ds_ctl.sqrt_mode = (state_q == BK_ROOT);
	assign ds_num           = (state_q == BK_ROOT) ? disc_q : s_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			BK_SETUP: begin
				unique case (idx_q)
					3'd0: begin mul_a = BW'(axis_b); mul_b = BW'(axis_c); end
					3'd1: begin mul_a = BW'(axis_a); mul_b = BW'(axis_c); end
					3'd2: begin mul_a = BW'(axis_a); mul_b = BW'(axis_b); end
					3'd3: begin mul_a = wq_q[2];     mul_b = BW'(axis_c); end
					3'd4: begin mul_a = u_q;         mul_b = u_q; end
					3'd5: begin mul_a = wq_q[0];     mul_b = wq_q[0]; end
					3'd6: begin mul_a = wq_q[1];     mul_b = wq_q[1]; end
					default: begin mul_a = wq_q[2];  mul_b = wq_q[2]; end
				endcase
			end
			BK_AXIS: begin
				unique case (sub_q)
					3'd0: begin mul_a = BW'(d_q[axis_q]); mul_b = BW'(d_q[axis_q]); end
					3'd2: begin mul_a = BW'(x_q[axis_q]); mul_b = BW'(d_q[axis_q]); end
					3'd4: begin mul_a = BW'(x_q[axis_q]); mul_b = BW'(x_q[axis_q]); end
					default: begin mul_a = wq_q[axis_q];  mul_b = t_q; end
				endcase
			end
			BK_DISC: begin
				if (idx_q[0]) begin
					mul_a = m_q;
					mul_b = k_q;
				end else begin
					mul_a = l_q;
					mul_b = l_q;
				end
			end
			BK_PMUL: begin
				mul_a = side_q ? np_q : nn_q;
				mul_b = BW'(d_q[axis_q]);
			end
			default: ;
		endcase
	end

	always_comb begin
		fits    = (s_q[BW-1:CW-1] == '0) || (s_q[BW-1:CW-1] == '1);
		sat_val = fits ? s_q[CW-1:0] :
			(s_q[BW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});
	end

	always_comb begin
		out_word = '0;
		for (int i = 0; i < 3; i++) begin
			out_word[i*CW +: CW]     = res_near_q[i];
			out_word[(3+i)*CW +: CW] = res_far_q[i];
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		sub_d    = sub_q;
		axis_d   = axis_q;
		side_d   = side_q;
		pend_d   = pend_q && !(mul_start || ds_ctl.start);
		q_pop    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (dzero)
						state_d = BK_OUT;
					else begin
						state_d = BK_SETUP;
						idx_d   = '0;
						pend_d  = 1'b1;
					end
				end
			end
			BK_SETUP: begin
				if (mul_sts.done) begin
					pend_d = 1'b1;
					if (idx_q == 3'd7) begin
						state_d = BK_AXIS;
						axis_d  = '0;
						sub_d   = '0;
					end else
						idx_d = idx_q + 1'b1;
				end
			end
			BK_AXIS: begin
				if (mul_sts.done) begin
					pend_d = 1'b1;
					if (sub_q == 3'd5) begin
						sub_d = '0;
						if (axis_q == 2'd2) begin
							state_d = BK_DISC;
							idx_d   = '0;
						end else
							axis_d = axis_q + 1'b1;
					end else
						sub_d = sub_q + 1'b1;
				end
			end
			BK_DISC: begin
				if (mul_sts.done) begin
					if (idx_q[0])
						state_d = BK_CHECK;
					else begin
						idx_d  = 3'd1;
						pend_d = 1'b1;
					end
				end
			end
			BK_CHECK: begin
				if (k_q == '0 || disc_q[BW-1])
					state_d = BK_OUT;
				else begin
					state_d = BK_ROOT;
					pend_d  = 1'b1;
				end
			end
			BK_ROOT: begin
				if (ds_sts.done)
					state_d = BK_PREP;
			end
			BK_PREP: begin
				state_d = BK_PMUL;
				axis_d  = '0;
				side_d  = 1'b0;
				pend_d  = 1'b1;
			end
			BK_PMUL: begin
				if (mul_sts.done) begin
					state_d = BK_PDIV;
					pend_d  = 1'b1;
				end
			end
			BK_PDIV: begin
				if (ds_sts.done)
					state_d = BK_PSAT;
			end
			BK_PSAT: begin
				if (axis_q == 2'd2 && side_q)
					state_d = BK_OUT;
				else begin
					state_d = BK_PMUL;
					pend_d  = 1'b1;
					if (axis_q == 2'd2) begin
						axis_d = '0;
						side_d = 1'b1;
					end else
						axis_d = axis_q + 1'b1;
				end
			end
			BK_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			idx_q      <= '0;
			sub_q      <= '0;
			axis_q     <= '0;
			side_q     <= 1'b0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			sub_q   <= sub_d;
			axis_q  <= axis_d;
			side_q  <= side_d;
			pend_q  <= pend_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 3; i++) begin
				p_q[i]        <= q_rdata[i*CW +: CW];
				d_q[i]        <= q_rdata[(3+i)*CW +: CW];
				x_q[i]        <= q_rdata[6*CW + i*(CW+1) +: CW+1];
				res_near_q[i] <= '0;
				res_far_q[i]  <= '0;
			end
			res_hit_q  <= 1'b0;
			res_clip_q <= 1'b0;
		end
		unique case (state_q)
			BK_SETUP: begin
				if (mul_sts.done) begin
					unique case (idx_q)
						3'd0: wq_q[0] <= mul_prod;
						3'd1: wq_q[1] <= mul_prod;
						3'd2: wq_q[2] <= mul_prod;
						3'd3: u_q <= mul_prod;
						3'd4: begin
							u_q <= mul_prod;
							m_q <= -mul_prod;
							k_q <= '0;
							l_q <= '0;
						end
						3'd5: wq_q[0] <= mul_prod;
						3'd6: wq_q[1] <= mul_prod;
						default: wq_q[2] <= mul_prod;
					endcase
				end
			end
			BK_AXIS: begin
				if (mul_sts.done) begin
					unique case (sub_q)
						3'd1: k_q <= k_q + mul_prod;
						3'd3: l_q <= l_q + mul_prod;
						3'd5: begin
							m_q <= m_q + mul_prod;
							if (axis_q == 2'd2)
								l_q <= l_q <<< 1;
						end
						default: t_q <= mul_prod;
					endcase
				end
			end
			BK_DISC: begin
				if (mul_sts.done) begin
					if (idx_q[0])
						disc_q <= disc_q - (mul_prod <<< 2);
					else
						disc_q <= mul_prod;
				end
			end
			BK_ROOT: begin
				if (ds_sts.done)
					r_q <= ds_res;
			end
			BK_PREP: begin
				nn_q  <= -l_q - r_q;
				np_q  <= r_q - l_q;
				den_q <= k_q <<< 1;
			end
			BK_PMUL: begin
				if (mul_sts.done)
					s_q <= mul_prod;
			end
			BK_PDIV: begin
				if (ds_sts.done)
					s_q <= ds_res + BW'(p_q[axis_q]);
			end
			BK_PSAT: begin
				if (side_q)
					res_far_q[axis_q] <= sat_val;
				else
					res_near_q[axis_q] <= sat_val;
				if (!fits)
					res_clip_q <= 1'b1;
				if (side_q && axis_q == 2'd2)
					res_hit_q <= 1'b1;
			end
			default: ;
		endcase
		if (out_load) begin
			m_tdata_q             <= out_word;
			m_tuser_q[TU_HIT]     <= res_hit_q;
			m_tuser_q[TU_CLIPPED] <= res_clip_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`LEI_NEVER(a_mul_overlap, mul_start && mul_sts.busy, "multiplier restarted while busy")
	`LEI_NEVER(a_ds_overlap, ds_ctl.start && ds_sts.busy, "div/sqrt restarted while busy")
	`LEI_ASSERT(a_mul_done_used, mul_sts.done |-> in_mul, "product in non-multiply state")
	`LEI_ASSERT(a_miss_clean, (m_tvalid && !m_tuser[TU_HIT]) |-> (m_tdata == '0 && !m_tuser[TU_CLIPPED]), "miss with nonzero payload")
endmodule
`default_nettype wire
